### hdl/picsh_pkg.sv
// Package: shared constants, register indexes and stage structs of the icon pixel shader.
`default_nettype none

package picsh_pkg;

    localparam int ICON_SIDE_DEF = 200;

    localparam int COORD_W  = 8;
    localparam int RADIUS_W = 7;
    localparam int COLOR_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int R2_W     = 2 * RADIUS_W;
    localparam int SUM_W    = SQ_W + 1;

    localparam logic [COORD_W-1:0] CENTER_X  = 8'd100;
    localparam logic [COORD_W-1:0] CENTER_Y  = 8'd100;
    localparam logic [COORD_W-1:0] LEFT_X    = 8'd77;
    localparam logic [COORD_W-1:0] RIGHT_X   = 8'd127;
    localparam logic [COORD_W-1:0] EYE_TOP_Y = 8'd92;
    localparam logic [COORD_W-1:0] EYE_BOT_Y = 8'd112;

    localparam logic [RADIUS_W-1:0] BALL_RADIUS_RST = 7'd70;
    localparam logic [RADIUS_W-1:0] EDGE_RADIUS_RST = 7'd72;
    localparam logic [RADIUS_W-1:0] EYE_RADIUS_RST  = 7'd8;
    localparam logic [COLOR_W-1:0]  CANVAS_COLOR_RST = 16'd2113;
    localparam logic [COLOR_W-1:0]  EDGE_COLOR_RST   = 16'd57083;
    localparam logic [COLOR_W-1:0]  BALL_COLOR_RST   = 16'd65502;
    localparam logic [COLOR_W-1:0]  EYE_COLOR_RST    = 16'd4258;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BALL_RADIUS  = 3'd0,
        REG_EDGE_RADIUS  = 3'd1,
        REG_EYE_RADIUS   = 3'd2,
        REG_CANVAS_COLOR = 3'd3,
        REG_EDGE_COLOR   = 3'd4,
        REG_BALL_COLOR   = 3'd5,
        REG_EYE_COLOR    = 3'd6
    } t_cfg_idx;

    // squared distances, after the multiply stage
    typedef struct packed {
        logic            valid;
        logic            oor;
        logic [SQ_W-1:0] sq_cx;
        logic [SQ_W-1:0] sq_cy;
        logic [SQ_W-1:0] sq_lx;
        logic [SQ_W-1:0] sq_rx;
        logic [SQ_W-1:0] sq_dy;
        logic [R2_W-1:0] r2_ball;
        logic [R2_W-1:0] r2_edge;
        logic [R2_W-1:0] r2_eye;
    } t_sq;

    // region flags, after the compare stage
    typedef struct packed {
        logic valid;
        logic oor;
        logic in_ball;
        logic in_ring;
        logic in_eye;
    } t_hit;

    function automatic logic [COORD_W-1:0] f_absdiff(input logic [COORD_W-1:0] a,
                                                     input logic [COORD_W-1:0] b);
        f_absdiff = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

### hdl/picsh_front.sv
// Front stages: coordinate offsets, then squared distances and squared radii.
`default_nettype none

module picsh_front #(
    parameter int ICON_SIDE = picsh_pkg::ICON_SIDE_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_en,
    input  wire                                   i_valid,
    input  wire  [picsh_pkg::COORD_W-1:0]         i_pixel_x,
    input  wire  [picsh_pkg::COORD_W-1:0]         i_pixel_y,
    input  wire  [picsh_pkg::RADIUS_W-1:0]        i_ball_radius,
    input  wire  [picsh_pkg::RADIUS_W-1:0]        i_edge_radius,
    input  wire  [picsh_pkg::RADIUS_W-1:0]        i_eye_radius,
    output picsh_pkg::t_sq                        o_sq
);

    localparam int W = picsh_pkg::COORD_W;

    logic         r_v1;
    logic         r_oor1;
    logic [W-1:0] r_dcx;
    logic [W-1:0] r_dcy;
    logic [W-1:0] r_dlx;
    logic [W-1:0] r_drx;
    logic [W-1:0] r_ddy;
    logic [W-1:0] n_ddy;
    logic         n_oor;
    picsh_pkg::t_sq r_sq;

    always_comb begin
        n_oor = (32'(i_pixel_x) >= 32'(ICON_SIDE)) || (32'(i_pixel_y) >= 32'(ICON_SIDE));
        if (i_pixel_y < picsh_pkg::EYE_TOP_Y) begin
            n_ddy = picsh_pkg::EYE_TOP_Y - i_pixel_y;
        end else if (i_pixel_y > picsh_pkg::EYE_BOT_Y) begin
            n_ddy = i_pixel_y - picsh_pkg::EYE_BOT_Y;
        end else begin
            n_ddy = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_sq.valid <= 1'b0;
        end else if (i_en) begin
            r_v1     <= i_valid;
            r_sq.valid <= r_v1;
        end
        if (i_en) begin
            r_oor1 <= n_oor;
            r_dcx  <= picsh_pkg::f_absdiff(i_pixel_x, picsh_pkg::CENTER_X);
            r_dcy  <= picsh_pkg::f_absdiff(i_pixel_y, picsh_pkg::CENTER_Y);
            r_dlx  <= picsh_pkg::f_absdiff(i_pixel_x, picsh_pkg::LEFT_X);
            r_drx  <= picsh_pkg::f_absdiff(i_pixel_x, picsh_pkg::RIGHT_X);
            r_ddy  <= n_ddy;

            r_sq.oor     <= r_oor1;
            r_sq.sq_cx   <= picsh_pkg::SQ_W'(r_dcx) * picsh_pkg::SQ_W'(r_dcx);
            r_sq.sq_cy   <= picsh_pkg::SQ_W'(r_dcy) * picsh_pkg::SQ_W'(r_dcy);
            r_sq.sq_lx   <= picsh_pkg::SQ_W'(r_dlx) * picsh_pkg::SQ_W'(r_dlx);
            r_sq.sq_rx   <= picsh_pkg::SQ_W'(r_drx) * picsh_pkg::SQ_W'(r_drx);
            r_sq.sq_dy   <= picsh_pkg::SQ_W'(r_ddy) * picsh_pkg::SQ_W'(r_ddy);
            r_sq.r2_ball <= picsh_pkg::R2_W'(i_ball_radius) * picsh_pkg::R2_W'(i_ball_radius);
            r_sq.r2_edge <= picsh_pkg::R2_W'(i_edge_radius) * picsh_pkg::R2_W'(i_edge_radius);
            r_sq.r2_eye  <= picsh_pkg::R2_W'(i_eye_radius) * picsh_pkg::R2_W'(i_eye_radius);
        end
    end

    assign o_sq = r_sq;

endmodule

`default_nettype wire

### hdl/picsh_cmp.sv
// Compare stage: ball, ring and eye capsule tests on squared distances.
`default_nettype none

module picsh_cmp (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_en,
    input  picsh_pkg::t_sq  i_sq,
    output picsh_pkg::t_hit o_hit
);

    localparam int S = picsh_pkg::SUM_W;

    logic [S-1:0] n_dc2;
    logic [S-1:0] n_dl2;
    logic [S-1:0] n_dr2;
    picsh_pkg::t_hit r_hit;

    // capsules are vertical, so distance folds to dx^2 + dy_outside^2
    always_comb begin
        n_dc2 = S'(i_sq.sq_cx) + S'(i_sq.sq_cy);
        n_dl2 = S'(i_sq.sq_lx) + S'(i_sq.sq_dy);
        n_dr2 = S'(i_sq.sq_rx) + S'(i_sq.sq_dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit.valid <= 1'b0;
        end else if (i_en) begin
            r_hit.valid <= i_sq.valid;
        end
        if (i_en) begin
            r_hit.oor     <= i_sq.oor;
            r_hit.in_ball <= n_dc2 < S'(i_sq.r2_ball);
            r_hit.in_ring <= n_dc2 < S'(i_sq.r2_edge);
            r_hit.in_eye  <= (n_dl2 < S'(i_sq.r2_eye)) || (n_dr2 < S'(i_sq.r2_eye));
        end
    end

    assign o_hit = r_hit;

endmodule

`default_nettype wire

### hdl/picsh_out.sv
// Output stage: color select into an output register with a one-word skid buffer.
`default_nettype none

module picsh_out (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  picsh_pkg::t_hit                i_hit,
    input  wire  [picsh_pkg::COLOR_W-1:0]  i_canvas_color,
    input  wire  [picsh_pkg::COLOR_W-1:0]  i_edge_color,
    input  wire  [picsh_pkg::COLOR_W-1:0]  i_ball_color,
    input  wire  [picsh_pkg::COLOR_W-1:0]  i_eye_color,
    output logic                           o_en,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic [picsh_pkg::COLOR_W-1:0]  o_pixel_color
);

    localparam int C = picsh_pkg::COLOR_W;

    logic         r_out_valid;
    logic [C-1:0] r_out_color;
    logic         r_skid_valid;
    logic [C-1:0] r_skid_color;
    logic [C-1:0] n_color;
    logic         push;
    logic         pop;

    always_comb begin
        priority if (i_hit.oor) begin
            n_color = i_canvas_color;
        end else if (i_hit.in_ball) begin
            n_color = i_hit.in_eye ? i_eye_color : i_ball_color;
        end else if (i_hit.in_ring) begin
            n_color = i_edge_color;
        end else begin
            n_color = i_canvas_color;
        end
    end

    assign o_en = !r_skid_valid;
    assign push = i_hit.valid && !r_skid_valid;
    assign pop  = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_color  <= r_skid_color;
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
                r_out_color <= n_color;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid_color <= n_color;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_color = r_out_color;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with empty output register");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && r_out_valid && !i_out_ready |=> r_skid_valid)
        else $error("word arriving on a stalled output was not caught by the skid");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_out_ready |=> r_skid_valid && $stable(r_skid_color))
        else $error("skid word changed or dropped while stalled");

endmodule

`default_nettype wire

### hdl/procedural_icon_pixel_shader_core.sv
// Top level: configuration registers and the four-stage pixel shader pipeline.
`default_nettype none

// Pixel shader for the sphere icon: one word (pixel_x, pixel_y) in, one RGB565
// word out. Throughput is one word per clock while o_in_ready is high; o_out_valid
// rises once the word has passed four registers (offsets, squares, compares,
// color register). The output register plus a one-word skid buffer catch the word
// that arrives while the sink stalls; o_in_ready then drops for as long as the skid
// word is held.
// Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data and must only be
// changed while no word is in flight.
module procedural_icon_pixel_shader_core #(
    parameter int ICON_SIDE = picsh_pkg::ICON_SIDE_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [picsh_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [picsh_pkg::COLOR_W-1:0]     i_cfg_data,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire  [picsh_pkg::COORD_W-1:0]     i_pixel_x,
    input  wire  [picsh_pkg::COORD_W-1:0]     i_pixel_y,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [picsh_pkg::COLOR_W-1:0]     o_pixel_color
);

    localparam int RW = picsh_pkg::RADIUS_W;
    localparam int CW = picsh_pkg::COLOR_W;

    logic [RW-1:0] r_ball_radius;
    logic [RW-1:0] r_edge_radius;
    logic [RW-1:0] r_eye_radius;
    logic [CW-1:0] r_canvas_color;
    logic [CW-1:0] r_edge_color;
    logic [CW-1:0] r_ball_color;
    logic [CW-1:0] r_eye_color;

    logic            en;
    picsh_pkg::t_sq  sq;
    picsh_pkg::t_hit hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ball_radius  <= picsh_pkg::BALL_RADIUS_RST;
            r_edge_radius  <= picsh_pkg::EDGE_RADIUS_RST;
            r_eye_radius   <= picsh_pkg::EYE_RADIUS_RST;
            r_canvas_color <= picsh_pkg::CANVAS_COLOR_RST;
            r_edge_color   <= picsh_pkg::EDGE_COLOR_RST;
            r_ball_color   <= picsh_pkg::BALL_COLOR_RST;
            r_eye_color    <= picsh_pkg::EYE_COLOR_RST;
        end else if (i_cfg_we) begin
            unique case (picsh_pkg::t_cfg_idx'(i_cfg_idx))
                picsh_pkg::REG_BALL_RADIUS:  r_ball_radius  <= i_cfg_data[RW-1:0];
                picsh_pkg::REG_EDGE_RADIUS:  r_edge_radius  <= i_cfg_data[RW-1:0];
                picsh_pkg::REG_EYE_RADIUS:   r_eye_radius   <= i_cfg_data[RW-1:0];
                picsh_pkg::REG_CANVAS_COLOR: r_canvas_color <= i_cfg_data;
                picsh_pkg::REG_EDGE_COLOR:   r_edge_color   <= i_cfg_data;
                picsh_pkg::REG_BALL_COLOR:   r_ball_color   <= i_cfg_data;
                picsh_pkg::REG_EYE_COLOR:    r_eye_color    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    picsh_front #(
        .ICON_SIDE (ICON_SIDE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_in_valid),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_ball_radius (r_ball_radius),
        .i_edge_radius (r_edge_radius),
        .i_eye_radius  (r_eye_radius),
        .o_sq          (sq)
    );

    picsh_cmp u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_sq    (sq),
        .o_hit   (hit)
    );

    picsh_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_hit          (hit),
        .i_canvas_color (r_canvas_color),
        .i_edge_color   (r_edge_color),
        .i_ball_color   (r_ball_color),
        .i_eye_color    (r_eye_color),
        .o_en           (en),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_color  (o_pixel_color)
    );

    assign o_in_ready = en;

endmodule

`default_nettype wire
